// ----- rtl/tic_pkg.sv -----
// package: widths, latency and divider stage type for the isoline crossing block
package tic_pkg;

  localparam int INDEX_BITS = 24;
  localparam int COORD_W    = 32;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int DIV_STEPS  = DIFF_W;
  localparam int NUM_EDGES  = 3;
  // front stage + seed stage + divide steps + final add
  localparam int INTERP_LAT = DIV_STEPS + 3;

  typedef struct packed {
    logic [DIFF_W-1:0]  rem;
    logic [DIFF_W-1:0]  low;
    logic [DIFF_W-1:0]  quo;
    logic [DIFF_W-1:0]  uz;
    logic               neg;
    logic [COORD_W-1:0] p0;
  } div_stage_t;

endpackage

// ----- rtl/tic_interp.sv -----
// pipelined edge interpolator: p0 + (p1 - p0) * (t - z0) / (z1 - z0), truncated toward zero
module tic_interp (
  input  logic                        clk,
  input  logic [tic_pkg::COORD_W-1:0] p0,
  input  logic [tic_pkg::COORD_W-1:0] p1,
  input  logic [tic_pkg::COORD_W-1:0] z0,
  input  logic [tic_pkg::COORD_W-1:0] z1,
  input  logic [tic_pkg::COORD_W-1:0] thr,
  output logic [tic_pkg::COORD_W-1:0] res
);
  import tic_pkg::*;

  logic [DIFF_W-1:0]  dp, dt, dz;
  logic [DIFF_W-1:0]  up_r, ut_r, uz_r;
  logic               neg_r;
  logic [COORD_W-1:0] p0_r;
  logic [PROD_W-1:0]  prod;
  div_stage_t         st_r [0:DIV_STEPS];
  div_stage_t         seed_nxt;
  logic [COORD_W-1:0] res_r, res_nxt;

  assign dp = {p1[COORD_W-1], p1} - {p0[COORD_W-1], p0};
  assign dt = {thr[COORD_W-1], thr} - {z0[COORD_W-1], z0};
  assign dz = {z1[COORD_W-1], z1} - {z0[COORD_W-1], z0};

  always_ff @(posedge clk) begin
    up_r  <= dp[DIFF_W-1] ? (~dp + DIFF_W'(1)) : dp;
    ut_r  <= dt[DIFF_W-1] ? (~dt + DIFF_W'(1)) : dt;
    uz_r  <= dz[DIFF_W-1] ? (~dz + DIFF_W'(1)) : dz;
    neg_r <= dp[DIFF_W-1] ^ dt[DIFF_W-1] ^ dz[DIFF_W-1];
    p0_r  <= p0;
  end

  assign prod = PROD_W'(up_r) * PROD_W'(ut_r);

  always_comb begin
    seed_nxt.rem = prod[PROD_W-1:DIFF_W];
    seed_nxt.low = prod[DIFF_W-1:0];
    seed_nxt.quo = '0;
    seed_nxt.uz  = uz_r;
    seed_nxt.neg = neg_r;
    seed_nxt.p0  = p0_r;
  end

  always_ff @(posedge clk) begin
    st_r[0] <= seed_nxt;
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic [DIFF_W:0]   trial;
    logic              ge;
    div_stage_t        st_nxt;
    always_comb begin
      trial      = {st_r[k-1].rem, st_r[k-1].low[DIFF_W-1]};
      ge         = trial >= {1'b0, st_r[k-1].uz};
      st_nxt     = st_r[k-1];
      st_nxt.rem = ge ? DIFF_W'(trial - {1'b0, st_r[k-1].uz}) : trial[DIFF_W-1:0];
      st_nxt.low = {st_r[k-1].low[DIFF_W-2:0], 1'b0};
      st_nxt.quo = {st_r[k-1].quo[DIFF_W-2:0], ge};
    end
    always_ff @(posedge clk) begin
      st_r[k] <= st_nxt;
    end
  end

  assign res_nxt = st_r[DIV_STEPS].neg ?
                   (st_r[DIV_STEPS].p0 - st_r[DIV_STEPS].quo[COORD_W-1:0]) :
                   (st_r[DIV_STEPS].p0 + st_r[DIV_STEPS].quo[COORD_W-1:0]);

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

// ----- rtl/triangle_isoline_crossing.sv -----
// top level: marching triangles contour segment for one triangle per beat
//
//  channel | ports                          | handshake
//  --------+--------------------------------+-------------------------------
//  input   | in_tri_index, in_ax .. in_cz   | start high and busy low
//  result  | out_index, out_edge_mask, pts  | out_valid strobe, one cycle
//  config  | cfg_wdata                      | cfg_we high
//
// one triangle accepted every cycle; busy stays low
// a taken beat passes the input register, then six interpolators of
// 36 stages each (33 of them restoring divide steps);
// the result ports come straight off the last interpolator stage
// synchronous reset clears valid bits and sets the threshold to zero
// the receiver cannot stall, so the pipeline never holds
module triangle_isoline_crossing (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [tic_pkg::INDEX_BITS-1:0] in_tri_index,
  input  logic [tic_pkg::COORD_W-1:0]    in_ax,
  input  logic [tic_pkg::COORD_W-1:0]    in_ay,
  input  logic [tic_pkg::COORD_W-1:0]    in_az,
  input  logic [tic_pkg::COORD_W-1:0]    in_bx,
  input  logic [tic_pkg::COORD_W-1:0]    in_by_coord,
  input  logic [tic_pkg::COORD_W-1:0]    in_bz,
  input  logic [tic_pkg::COORD_W-1:0]    in_cx,
  input  logic [tic_pkg::COORD_W-1:0]    in_cy,
  input  logic [tic_pkg::COORD_W-1:0]    in_cz,
  input  logic                           cfg_we,
  input  logic [tic_pkg::COORD_W-1:0]    cfg_wdata,
  output logic                           out_valid,
  output logic [tic_pkg::INDEX_BITS-1:0] out_index,
  output logic [tic_pkg::NUM_EDGES-1:0]  out_edge_mask,
  output logic [tic_pkg::COORD_W-1:0]    out_ab_x,
  output logic [tic_pkg::COORD_W-1:0]    out_ab_y,
  output logic [tic_pkg::COORD_W-1:0]    out_ac_x,
  output logic [tic_pkg::COORD_W-1:0]    out_ac_y,
  output logic [tic_pkg::COORD_W-1:0]    out_bc_x,
  output logic [tic_pkg::COORD_W-1:0]    out_bc_y
);
  import tic_pkg::*;

  logic [COORD_W-1:0]    thr_r;
  logic                  vin_r;
  logic [INDEX_BITS-1:0] idx_r;
  logic [COORD_W-1:0]    ax_r, ay_r, az_r, bx_r, by_r, bz_r, cx_r, cy_r, cz_r;
  logic [NUM_EDGES-1:0]  mask_nxt;

  logic                  vld_r  [0:INTERP_LAT-1];
  logic [INDEX_BITS-1:0] idxd_r [0:INTERP_LAT-1];
  logic [NUM_EDGES-1:0]  mskd_r [0:INTERP_LAT-1];

  logic [COORD_W-1:0]    ab_x, ab_y, ac_x, ac_y, bc_x, bc_y;
  logic                  keep;

  function automatic logic straddle(input logic [COORD_W-1:0] za,
                                    input logic [COORD_W-1:0] zb,
                                    input logic [COORD_W-1:0] t);
    logic signed [COORD_W-1:0] sa, sb, st;
    sa = za;
    sb = zb;
    st = t;
    return ((sa < st) && (sb > st)) || ((sa > st) && (sb < st));
  endfunction

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vin_r <= 1'b0;
    end else begin
      vin_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= in_tri_index;
    ax_r  <= in_ax;
    ay_r  <= in_ay;
    az_r  <= in_az;
    bx_r  <= in_bx;
    by_r  <= in_by_coord;
    bz_r  <= in_bz;
    cx_r  <= in_cx;
    cy_r  <= in_cy;
    cz_r  <= in_cz;
  end

  assign mask_nxt = {straddle(bz_r, cz_r, thr_r),
                     straddle(az_r, cz_r, thr_r),
                     straddle(az_r, bz_r, thr_r)};

  // valid, index and mask travel alongside the interpolators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < INTERP_LAT; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= vin_r;
      for (int i = 1; i < INTERP_LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    idxd_r[0] <= idx_r;
    mskd_r[0] <= mask_nxt;
    for (int i = 1; i < INTERP_LAT; i++) begin
      idxd_r[i] <= idxd_r[i-1];
      mskd_r[i] <= mskd_r[i-1];
    end
  end

  tic_interp u_ab_x (.clk, .p0(ax_r), .p1(bx_r), .z0(az_r), .z1(bz_r), .thr(thr_r), .res(ab_x));
  tic_interp u_ab_y (.clk, .p0(ay_r), .p1(by_r), .z0(az_r), .z1(bz_r), .thr(thr_r), .res(ab_y));
  tic_interp u_ac_x (.clk, .p0(cx_r), .p1(ax_r), .z0(cz_r), .z1(az_r), .thr(thr_r), .res(ac_x));
  tic_interp u_ac_y (.clk, .p0(cy_r), .p1(ay_r), .z0(cz_r), .z1(az_r), .thr(thr_r), .res(ac_y));
  tic_interp u_bc_x (.clk, .p0(bx_r), .p1(cx_r), .z0(bz_r), .z1(cz_r), .thr(thr_r), .res(bc_x));
  tic_interp u_bc_y (.clk, .p0(by_r), .p1(cy_r), .z0(bz_r), .z1(cz_r), .thr(thr_r), .res(bc_y));

  // exactly two crossed edges make a segment
  always_comb begin
    case (mskd_r[INTERP_LAT-1])
      3'b011, 3'b101, 3'b110: keep = 1'b1;
      default:                keep = 1'b0;
    endcase
  end

  assign out_valid     = vld_r[INTERP_LAT-1] && keep;
  assign out_index     = idxd_r[INTERP_LAT-1];
  assign out_edge_mask = mskd_r[INTERP_LAT-1];
  assign out_ab_x      = mskd_r[INTERP_LAT-1][0] ? ab_x : '0;
  assign out_ab_y      = mskd_r[INTERP_LAT-1][0] ? ab_y : '0;
  assign out_ac_x      = mskd_r[INTERP_LAT-1][1] ? ac_x : '0;
  assign out_ac_y      = mskd_r[INTERP_LAT-1][1] ? ac_y : '0;
  assign out_bc_x      = mskd_r[INTERP_LAT-1][2] ? bc_x : '0;
  assign out_bc_y      = mskd_r[INTERP_LAT-1][2] ? bc_y : '0;

  a_two_edges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones(out_edge_mask) == 2))
    else $error("segment without exactly two crossed edges");

  a_from_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, INTERP_LAT + 1))
    else $error("result without a matching input beat");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("pipeline refused a beat");

endmodule

// ----- bench/triangle_isoline_crossing_tb.sv -----
// testbench: directed and random triangles checked against an isoline crossing predictor
`timescale 1ns / 1ps

module triangle_isoline_crossing_tb;
  import tic_pkg::*;

  localparam int LATENCY = 36;

  typedef struct packed {
    logic [INDEX_BITS-1:0] idx;
    logic [31:0] ax, ay, az, bx, by, bz, cx, cy, cz;
  } tri_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] idx;
    logic [2:0] mask;
    logic [31:0] abx, aby, acx, acy, bcx, bcy;
  } seg_t;

  typedef struct {
    tri_t tri_in;
    bit   has_seg;
    seg_t seg;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [INDEX_BITS-1:0] in_tri_index = '0;
  logic [31:0] in_ax = 0, in_ay = 0, in_az = 0, in_bx = 0, in_by_coord = 0, in_bz = 0;
  logic [31:0] in_cx = 0, in_cy = 0, in_cz = 0;
  logic cfg_we = 0;
  logic [31:0] cfg_wdata = 0;
  logic out_valid;
  logic [INDEX_BITS-1:0] out_index;
  logic [2:0] out_edge_mask;
  logic [31:0] out_ab_x, out_ab_y, out_ac_x, out_ac_y, out_bc_x, out_bc_y;

  logic signed [31:0] level = 0;
  seg_t pending_segs[$];
  int errors = 0;

  triangle_isoline_crossing dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  initial begin
    #50_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got, exp);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  function automatic bit crosses(logic signed [31:0] z0, z1, t);
    return (z0 < t && z1 > t) || (z0 > t && z1 < t);
  endfunction

  function automatic logic [31:0] lerp(logic signed [31:0] p0, p1, z0, z1, t);
    logic signed [32:0] dp, dt, dz;
    logic signed [65:0] prod, q;
    dp = 33'(p1) - 33'(p0);
    dt = 33'(t) - 33'(z0);
    dz = 33'(z1) - 33'(z0);
    prod = 66'(dp) * 66'(dt);
    q = prod / 66'(dz);
    return 32'(66'(p0) + q);
  endfunction

  function automatic bit crossing_segment(tri_t tr, logic signed [31:0] t, output seg_t s);
    logic signed [31:0] za, zb, zc;
    int n;
    za = tr.az; zb = tr.bz; zc = tr.cz;
    s = '0;
    n = 0;
    if (za == zb && zb == zc) return 0;
    if (crosses(za, zb, t)) begin
      s.mask[0] = 1; n++;
      s.abx = lerp(tr.ax, tr.bx, za, zb, t);
      s.aby = lerp(tr.ay, tr.by, za, zb, t);
    end
    if (crosses(za, zc, t)) begin
      s.mask[1] = 1; n++;
      s.acx = lerp(tr.cx, tr.ax, zc, za, t);
      s.acy = lerp(tr.cy, tr.ay, zc, za, t);
    end
    if (crosses(zb, zc, t)) begin
      s.mask[2] = 1; n++;
      s.bcx = lerp(tr.bx, tr.cx, zb, zc, t);
      s.bcy = lerp(tr.by, tr.cy, zb, zc, t);
    end
    if (n != 2) return 0;
    s.idx = tr.idx;
    return 1;
  endfunction

  always @(posedge clk) begin
    seg_t e;
    if (rst_n && out_valid) begin
      if (pending_segs.size() == 0) begin
        report_mismatch("unexpected beat", out_index, 0);
      end else begin
        e = pending_segs.pop_front();
        if (out_index !== e.idx) report_mismatch("index", out_index, e.idx);
        if (out_edge_mask !== e.mask) report_mismatch("edge_mask", out_edge_mask, e.mask);
        if (out_ab_x !== e.abx) report_mismatch("ab_x", out_ab_x, e.abx);
        if (out_ab_y !== e.aby) report_mismatch("ab_y", out_ab_y, e.aby);
        if (out_ac_x !== e.acx) report_mismatch("ac_x", out_ac_x, e.acx);
        if (out_ac_y !== e.acy) report_mismatch("ac_y", out_ac_y, e.acy);
        if (out_bc_x !== e.bcx) report_mismatch("bc_x", out_bc_x, e.bcx);
        if (out_bc_y !== e.bcy) report_mismatch("bc_y", out_bc_y, e.bcy);
      end
    end
  end

  task automatic write_threshold(input logic [31:0] v);
    @(negedge clk);
    cfg_we = 1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 0;
    level = v;
  endtask

  task automatic drain();
    while (pending_segs.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // called at a falling edge; leaves start high, returns after the accepting edge
  task automatic send_tri(input tri_t tr, input bit allow_gap);
    seg_t s;
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      start = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    start = 1;
    in_tri_index = tr.idx;
    in_ax = tr.ax; in_ay = tr.ay; in_az = tr.az;
    in_bx = tr.bx; in_by_coord = tr.by; in_bz = tr.bz;
    in_cx = tr.cx; in_cy = tr.cy; in_cz = tr.cz;
    do @(posedge clk); while (busy);
    if (crossing_segment(tr, level, s)) pending_segs = {pending_segs, s};
    @(negedge clk);
  endtask

  function automatic logic [31:0] rnd_val(logic signed [31:0] t);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return t;
      2: return t + $urandom_range(1, 1000);
      3: return t - $urandom_range(1, 1000);
      4: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return t + 32'($signed($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic tri_t rnd_tri(logic signed [31:0] t);
    tri_t tr;
    tr.idx = INDEX_BITS'($urandom);
    tr.ax = rnd_coord(); tr.ay = rnd_coord();
    tr.bx = rnd_coord(); tr.by = rnd_coord();
    tr.cx = rnd_coord(); tr.cy = rnd_coord();
    tr.az = rnd_val(t); tr.bz = rnd_val(t); tr.cz = rnd_val(t);
    // mostly force az and bz to straddle the level so that edge ab crosses and a segment is likely
    if ($urandom_range(0, 9) < 7 && t != 32'h7fffffff && t != 32'h80000000) begin
      tr.az = t - $urandom_range(1, 100000);
      tr.bz = t + $urandom_range(1, 100000);
      if ($urandom_range(0, 1)) {tr.az, tr.bz} = {tr.bz, tr.az};
    end
    return tr;
  endfunction

  row_t rows[$];
  logic [31:0] levels[5] = '{32'h0001_0000, 32'h7fffffff, 32'h80000000,
                             32'hfff8_0000, 32'h0};

  initial begin
    row_t r;
    seg_t s;
    repeat (6) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // directed rows at threshold zero after reset
    r.tri_in = '{24'h000001, 0, 0, 32'hffff0000, 32'h00020000, 0, 32'h00010000,
                 0, 32'h00020000, 32'h00010000};
    r.has_seg = 1;
    r.seg = '{24'h000001, 3'b011, 32'h00010000, 0, 0, 32'h00010000, 0, 0};
    rows = {rows, r};
    r.has_seg = 0;
    r.tri_in = '{24'hffffff, 1, 2, 32'h5, 3, 4, 32'h5, 5, 6, 32'h5};
    rows = {rows, r};
    r.tri_in = '{24'h0, 1, 2, 32'h1, 3, 4, 32'h2, 5, 6, 32'h3};
    rows = {rows, r};
    r.tri_in = '{24'h0, 1, 2, 32'hffffffff, 3, 4, 32'hfffffffe, 5, 6, 32'h80000000};
    rows = {rows, r};
    r.tri_in = '{24'h2, 1, 2, 32'h0, 3, 4, 32'h1, 5, 6, 32'hffffffff};
    rows = {rows, r};
    r.tri_in = '{24'h3, 1, 2, 32'h0, 3, 4, 32'h0, 5, 6, 32'h7};
    rows = {rows, r};
    r.has_seg = 1;
    r.tri_in = '{24'h800000, 32'h80000000, 32'h7fffffff, 32'h80000000,
                 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                 32'h80000000, 32'h7fffffff, 32'h7fffffff};
    rows = {rows, r};
    r.tri_in = '{24'h555555, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                 32'h80000000, 32'h7fffffff, 32'h80000000,
                 32'h12345678, 32'hedcba987, 32'hffffffff};
    rows = {rows, r};
    r.tri_in = '{24'haaaaaa, 32'h00010000, 32'h0, 32'h1, 32'h0, 32'h00010000,
                 32'hffffffff, 32'h0, 32'h0, 32'h1};
    rows = {rows, r};

    foreach (rows[i]) begin
      send_tri(rows[i].tri_in, 0);
      if (rows[i].has_seg && i == 0) begin
        // row typed in: compare predictor with the hand value once
        void'(crossing_segment(rows[i].tri_in, level, s));
        if (s !== rows[i].seg) report_mismatch("directed row", s[31:0], rows[i].seg[31:0]);
      end else if (!rows[i].has_seg && i > 0 && i < 6) begin
        if (crossing_segment(rows[i].tri_in, level, s)) report_mismatch("no-beat row", i, 0);
      end
    end
    start = 0;
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 5) write_threshold(levels[ph]);
      else write_threshold($urandom);
      for (int k = 0; k < 100; k++) send_tri(rnd_tri(level), k < 80);
      start = 0;
      drain();
    end

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
